// ===== rtl/cfo_pkg.sv =====
`timescale 1ns / 1ps
package cfo_pkg;

   localparam int SAMPLE_WIDTH  = 16;
   localparam int SMOOTH_WIDTH  = 32;
   localparam int PHASE_WIDTH   = 32;
   localparam int CORDIC_STAGES = 16;
   localparam int ALPHA_WIDTH   = 16;
   localparam int ANGLE_WIDTH   = 32;
   localparam int GUARD_BITS    = 16;
   localparam int GAIN_WIDTH    = 16;

   localparam int PROD_WIDTH    = 2 * SAMPLE_WIDTH;
   localparam int PSUM_WIDTH    = 2 * SAMPLE_WIDTH + 1;
   localparam int PSHIFT        = 2 * SAMPLE_WIDTH + 1 - SMOOTH_WIDTH;
   localparam int PWIDE_WIDTH   = PSUM_WIDTH + SMOOTH_WIDTH;
   localparam int DIFF_WIDTH    = SMOOTH_WIDTH + 1;
   localparam int STEP_WIDTH    = DIFF_WIDTH + ALPHA_WIDTH + 1;
   localparam int SUM_WIDTH     = SMOOTH_WIDTH + 3;
   localparam int VEC_WIDTH     = SMOOTH_WIDTH + 4;
   localparam int ROT_WIDTH     = SAMPLE_WIDTH + GUARD_BITS + 4;
   localparam int ZROT_WIDTH    = ANGLE_WIDTH + 2;
   localparam int GPROD_WIDTH   = ROT_WIDTH + GAIN_WIDTH + 1;
   localparam int TAB_DEPTH     = 24;
   localparam int TAB_IDX_WIDTH = $clog2(TAB_DEPTH);

   localparam logic [ALPHA_WIDTH-1:0] ALPHA_RESET = ALPHA_WIDTH'(655);
   localparam logic [GAIN_WIDTH-1:0]  GAIN_Q16    = GAIN_WIDTH'(39797);

   localparam logic signed [SUM_WIDTH-1:0] SMOOTH_HI =
      SUM_WIDTH'((64'sd1 <<< (SMOOTH_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SUM_WIDTH-1:0] SMOOTH_LO = -SMOOTH_HI - SUM_WIDTH'(1);
   localparam logic signed [GPROD_WIDTH-1:0] SAMPLE_HI =
      GPROD_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [GPROD_WIDTH-1:0] SAMPLE_LO = -SAMPLE_HI - GPROD_WIDTH'(1);
   localparam logic signed [GPROD_WIDTH-1:0] ROUND_HALF =
      GPROD_WIDTH'(64'sd1 <<< (15 + GUARD_BITS));
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX =
      SAMPLE_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);

   localparam logic [ANGLE_WIDTH-1:0] ATAN_TAB [TAB_DEPTH] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670675, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   typedef struct packed {
      logic                        valid;
      logic                        zero;
      logic signed [VEC_WIDTH-1:0] x;
      logic signed [VEC_WIDTH-1:0] y;
      logic [ANGLE_WIDTH-1:0]      z;
   } vec_type;

   typedef struct packed {
      logic                         valid;
      logic signed [ROT_WIDTH-1:0]  x;
      logic signed [ROT_WIDTH-1:0]  y;
      logic signed [ZROT_WIDTH-1:0] z;
   } rot_type;

   function automatic logic signed [SMOOTH_WIDTH-1:0] scale_prod(
      input logic signed [PSUM_WIDTH-1:0] v);
      logic signed [PWIDE_WIDTH-1:0] w;
      w = PWIDE_WIDTH'(v);
      if (PSHIFT >= 0) begin
         w = w >>> PSHIFT;
      end else begin
         w = w <<< (-PSHIFT);
      end
      return w[SMOOTH_WIDTH-1:0];
   endfunction

   function automatic logic signed [SMOOTH_WIDTH-1:0] sat_smooth(
      input logic signed [SUM_WIDTH-1:0] v);
      logic signed [SUM_WIDTH-1:0] r;
      if (v > SMOOTH_HI) begin
         r = SMOOTH_HI;
      end else if (v < SMOOTH_LO) begin
         r = SMOOTH_LO;
      end else begin
         r = v;
      end
      return r[SMOOTH_WIDTH-1:0];
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
      input logic signed [GPROD_WIDTH-1:0] v);
      logic signed [GPROD_WIDTH-1:0] r;
      if (v > SAMPLE_HI) begin
         r = SAMPLE_HI;
      end else if (v < SAMPLE_LO) begin
         r = SAMPLE_LO;
      end else begin
         r = v;
      end
      return r[SAMPLE_WIDTH-1:0];
   endfunction

   // negation with the most negative code pinned to full scale
   function automatic logic signed [SAMPLE_WIDTH-1:0] neg_sat(
      input logic signed [SAMPLE_WIDTH-1:0] v);
      logic signed [SAMPLE_WIDTH-1:0] r;
      if (v == -SAMPLE_MAX - SAMPLE_WIDTH'(1)) begin
         r = SAMPLE_MAX;
      end else begin
         r = -v;
      end
      return r;
   endfunction

endpackage

// ===== rtl/cfo_sample_if.sv =====
`timescale 1ns / 1ps
interface cfo_sample_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [cfo_pkg::SAMPLE_WIDTH-1:0]  sample_i;
   logic signed [cfo_pkg::SAMPLE_WIDTH-1:0]  sample_q;
   modport source(output valid, output sample_i, output sample_q, input ready);
   modport sink(input valid, input sample_i, input sample_q, output ready);
endinterface

// ===== rtl/cfo_corr_if.sv =====
`timescale 1ns / 1ps
interface cfo_corr_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [cfo_pkg::SAMPLE_WIDTH-1:0]  corrected_i;
   logic signed [cfo_pkg::SAMPLE_WIDTH-1:0]  corrected_q;
   modport source(output valid, output corrected_i, output corrected_q, input ready);
   modport sink(input valid, input corrected_i, input corrected_q, output ready);
endinterface

// ===== rtl/cfo_csr_if.sv =====
`timescale 1ns / 1ps
interface cfo_csr_if;
   logic                             valid;
   logic                             ready;
   logic [cfo_pkg::ALPHA_WIDTH-1:0]  alpha;
   modport source(output valid, output alpha, input ready);
   modport sink(input valid, input alpha, output ready);
endinterface

// ===== rtl/cfo_vec_cell.sv =====
`timescale 1ns / 1ps
module cfo_vec_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [cfo_pkg::TAB_IDX_WIDTH-1:0]  stage_idx,
   input  cfo_pkg::vec_type                   up,
   output cfo_pkg::vec_type                   down
);
   cfo_pkg::vec_type cell_ff, cell_in;
   logic signed [cfo_pkg::VEC_WIDTH-1:0] dx, dy;
   logic [cfo_pkg::ANGLE_WIDTH-1:0] step_ang;

   always_comb begin
      dx = up.x >>> stage_idx;
      dy = up.y >>> stage_idx;
      step_ang = cfo_pkg::ATAN_TAB[stage_idx];
      cell_in = up;
      // drive y towards zero
      if (!up.y[cfo_pkg::VEC_WIDTH-1] && (up.y != '0)) begin
         cell_in.x = up.x + dy;
         cell_in.y = up.y - dx;
         cell_in.z = up.z + step_ang;
      end else begin
         cell_in.x = up.x - dy;
         cell_in.y = up.y + dx;
         cell_in.z = up.z - step_ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= up.valid;
      end
      cell_ff.zero <= cell_in.zero;
      cell_ff.x    <= cell_in.x;
      cell_ff.y    <= cell_in.y;
      cell_ff.z    <= cell_in.z;
   end

   assign down = cell_ff;
endmodule

// ===== rtl/cfo_rot_cell.sv =====
`timescale 1ns / 1ps
module cfo_rot_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [cfo_pkg::TAB_IDX_WIDTH-1:0]  stage_idx,
   input  cfo_pkg::rot_type                   up,
   output cfo_pkg::rot_type                   down
);
   cfo_pkg::rot_type cell_ff, cell_in;
   logic signed [cfo_pkg::ROT_WIDTH-1:0] dx, dy;
   logic signed [cfo_pkg::ZROT_WIDTH-1:0] step_ang;

   always_comb begin
      dx = up.x >>> stage_idx;
      dy = up.y >>> stage_idx;
      step_ang = $signed({2'b00, cfo_pkg::ATAN_TAB[stage_idx]});
      cell_in = up;
      if (!up.z[cfo_pkg::ZROT_WIDTH-1]) begin
         cell_in.x = up.x - dy;
         cell_in.y = up.y + dx;
         cell_in.z = up.z - step_ang;
      end else begin
         cell_in.x = up.x + dy;
         cell_in.y = up.y - dx;
         cell_in.z = up.z + step_ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= up.valid;
      end
      cell_ff.x <= cell_in.x;
      cell_ff.y <= cell_in.y;
      cell_ff.z <= cell_in.z;
   end

   assign down = cell_ff;
endmodule

// ===== rtl/carrier_frequency_offset_corrector.sv =====
`timescale 1ns / 1ps
// path: an accepted sample runs through the product and smoothing registers, the vectoring
//   cordic row, the phase accumulator, the rotating cordic row, the gain and output registers
// throughput: one sample at a time, a new beat is taken the cycle after the previous result
//   reaches the output register, which is loaded only while rsp can take it
// reset: synchronous, clears history, smoothed vector, phase and the pipeline; alpha to 655
module carrier_frequency_offset_corrector (
   input  logic             clock,
   input  logic             reset,
   cfo_sample_if.sink       req_bus,
   cfo_corr_if.source       rsp_bus,
   cfo_csr_if.sink          csr_bus
);
   localparam int N  = cfo_pkg::CORDIC_STAGES;
   localparam int SW = cfo_pkg::SAMPLE_WIDTH;

   logic [cfo_pkg::ALPHA_WIDTH-1:0] alpha_ff;
   logic busy_ff;
   logic req_fire, out_load;

   logic signed [SW-1:0] cur_i_ff, cur_q_ff, pci_ff, pcq_ff;
   logic signed [cfo_pkg::PROD_WIDTH-1:0] pii_ff, pqq_ff, piq_ff, pqi_ff;
   logic signed [cfo_pkg::SMOOTH_WIDTH-1:0] pr_ff, pim_ff, sm_re_ff, sm_im_ff;
   logic signed [cfo_pkg::DIFF_WIDTH-1:0] d_re, d_im;
   logic signed [cfo_pkg::STEP_WIDTH-1:0] step_re_ff, step_im_ff;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, ph_valid_ff, g_valid_ff;
   logic [cfo_pkg::PHASE_WIDTH-1:0] acc_ff;
   logic [cfo_pkg::ANGLE_WIDTH-1:0] ang;
   logic signed [cfo_pkg::GPROD_WIDTH-1:0] gx_ff, gy_ff;
   logic rsp_valid_ff;
   logic signed [SW-1:0] corr_i_ff, corr_q_ff;

   cfo_pkg::vec_type v0_ff, v0_in;
   cfo_pkg::rot_type r0_ff, r0_in;
   cfo_pkg::vec_type vchain [N+1];
   cfo_pkg::rot_type rchain [N+1];

   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !busy_ff;
   assign csr_bus.ready = 1'b1;
   assign out_load      = g_valid_ff && (!rsp_valid_ff || rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= cfo_pkg::ALPHA_RESET;
      end else if (csr_bus.valid) begin
         alpha_ff <= csr_bus.alpha;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (req_fire) begin
         busy_ff <= 1'b1;
      end else if (out_load) begin
         busy_ff <= 1'b0;
      end
   end

   // products against the stored conjugate of the previous sample
   always_ff @(posedge clock) begin
      if (reset) begin
         pci_ff <= '0;
         pcq_ff <= '0;
      end else if (req_fire) begin
         pci_ff <= req_bus.sample_i;
         pcq_ff <= cfo_pkg::neg_sat(req_bus.sample_q);
      end
      if (req_fire) begin
         cur_i_ff <= req_bus.sample_i;
         cur_q_ff <= req_bus.sample_q;
         pii_ff   <= req_bus.sample_i * pci_ff;
         pqq_ff   <= req_bus.sample_q * pcq_ff;
         piq_ff   <= req_bus.sample_i * pcq_ff;
         pqi_ff   <= req_bus.sample_q * pci_ff;
      end
   end

   always_comb begin
      d_re = cfo_pkg::DIFF_WIDTH'(pr_ff) - cfo_pkg::DIFF_WIDTH'(sm_re_ff);
      d_im = cfo_pkg::DIFF_WIDTH'(pim_ff) - cfo_pkg::DIFF_WIDTH'(sm_im_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         sm_re_ff    <= '0;
         sm_im_ff    <= '0;
      end else begin
         s1_valid_ff <= req_fire;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         if (s3_valid_ff) begin
            sm_re_ff <= cfo_pkg::sat_smooth(cfo_pkg::SUM_WIDTH'(sm_re_ff)
                        + cfo_pkg::SUM_WIDTH'(step_re_ff >>> cfo_pkg::ALPHA_WIDTH));
            sm_im_ff <= cfo_pkg::sat_smooth(cfo_pkg::SUM_WIDTH'(sm_im_ff)
                        + cfo_pkg::SUM_WIDTH'(step_im_ff >>> cfo_pkg::ALPHA_WIDTH));
         end
      end
      if (s1_valid_ff) begin
         pr_ff  <= cfo_pkg::scale_prod(cfo_pkg::PSUM_WIDTH'(pii_ff)
                   - cfo_pkg::PSUM_WIDTH'(pqq_ff));
         pim_ff <= cfo_pkg::scale_prod(cfo_pkg::PSUM_WIDTH'(piq_ff)
                   + cfo_pkg::PSUM_WIDTH'(pqi_ff));
      end
      if (s2_valid_ff) begin
         step_re_ff <= d_re * $signed({1'b0, alpha_ff});
         step_im_ff <= d_im * $signed({1'b0, alpha_ff});
      end
   end

   // fold the smoothed vector into the right half plane
   always_comb begin
      v0_in.valid = s4_valid_ff;
      v0_in.zero  = (sm_re_ff == '0) && (sm_im_ff == '0);
      if (sm_re_ff[cfo_pkg::SMOOTH_WIDTH-1]) begin
         v0_in.x = -cfo_pkg::VEC_WIDTH'(sm_re_ff);
         v0_in.y = -cfo_pkg::VEC_WIDTH'(sm_im_ff);
         v0_in.z = {1'b1, {(cfo_pkg::ANGLE_WIDTH-1){1'b0}}};
      end else begin
         v0_in.x = cfo_pkg::VEC_WIDTH'(sm_re_ff);
         v0_in.y = cfo_pkg::VEC_WIDTH'(sm_im_ff);
         v0_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff.valid <= 1'b0;
      end else begin
         v0_ff.valid <= v0_in.valid;
      end
      v0_ff.zero <= v0_in.zero;
      v0_ff.x    <= v0_in.x;
      v0_ff.y    <= v0_in.y;
      v0_ff.z    <= v0_in.z;
   end

   assign vchain[0] = v0_ff;
   for (genvar g = 0; g < N; g++) begin : g_vec
      cfo_vec_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (cfo_pkg::TAB_IDX_WIDTH'(g)),
         .up        (vchain[g]),
         .down      (vchain[g+1])
      );
   end

   assign ang = vchain[N].zero ? '0 : vchain[N].z;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         ph_valid_ff <= 1'b0;
      end else begin
         ph_valid_ff <= vchain[N].valid;
         if (vchain[N].valid) begin
            acc_ff <= acc_ff - ang[cfo_pkg::ANGLE_WIDTH-1 -: cfo_pkg::PHASE_WIDTH];
         end
      end
   end

   // bring the phase within a quarter turn, flipping the sample
   always_comb begin
      logic signed [cfo_pkg::ANGLE_WIDTH-1:0] ph32;
      logic signed [cfo_pkg::ZROT_WIDTH-1:0] z0, quarter, half;
      ph32    = $signed(cfo_pkg::ANGLE_WIDTH'(acc_ff)
                << (cfo_pkg::ANGLE_WIDTH - cfo_pkg::PHASE_WIDTH));
      z0      = cfo_pkg::ZROT_WIDTH'(ph32);
      quarter = cfo_pkg::ZROT_WIDTH'(64'sd1 <<< (cfo_pkg::ANGLE_WIDTH - 2));
      half    = cfo_pkg::ZROT_WIDTH'(64'sd1 <<< (cfo_pkg::ANGLE_WIDTH - 1));
      r0_in.valid = ph_valid_ff;
      r0_in.x = cfo_pkg::ROT_WIDTH'(cur_i_ff) <<< cfo_pkg::GUARD_BITS;
      r0_in.y = cfo_pkg::ROT_WIDTH'(cur_q_ff) <<< cfo_pkg::GUARD_BITS;
      r0_in.z = z0;
      if ((z0 > quarter) || (z0 < -quarter)) begin
         r0_in.x = -r0_in.x;
         r0_in.y = -r0_in.y;
         r0_in.z = !z0[cfo_pkg::ZROT_WIDTH-1] ? (z0 - half) : (z0 + half);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r0_ff.valid <= 1'b0;
      end else begin
         r0_ff.valid <= r0_in.valid;
      end
      r0_ff.x <= r0_in.x;
      r0_ff.y <= r0_in.y;
      r0_ff.z <= r0_in.z;
   end

   assign rchain[0] = r0_ff;
   for (genvar g = 0; g < N; g++) begin : g_rot
      cfo_rot_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (cfo_pkg::TAB_IDX_WIDTH'(g)),
         .up        (rchain[g]),
         .down      (rchain[g+1])
      );
   end

   // gain stage holds its beat until the output register is free
   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (rchain[N].valid) begin
         g_valid_ff <= 1'b1;
      end else if (out_load) begin
         g_valid_ff <= 1'b0;
      end
      if (rchain[N].valid) begin
         gx_ff <= rchain[N].x * $signed({1'b0, cfo_pkg::GAIN_Q16});
         gy_ff <= rchain[N].y * $signed({1'b0, cfo_pkg::GAIN_Q16});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         corr_i_ff <= cfo_pkg::sat_sample((gx_ff + cfo_pkg::ROUND_HALF)
                      >>> (16 + cfo_pkg::GUARD_BITS));
         corr_q_ff <= cfo_pkg::sat_sample((gy_ff + cfo_pkg::ROUND_HALF)
                      >>> (16 + cfo_pkg::GUARD_BITS));
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.corrected_i = corr_i_ff;
   assign rsp_bus.corrected_q = corr_q_ff;

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> busy_ff)
      else $error("busy not set after accepted beat");

   a_load_while_busy : assert property (@(posedge clock) disable iff (reset)
      out_load |-> busy_ff)
      else $error("result loaded with no sample in flight");

   a_single_in_flight : assert property (@(posedge clock) disable iff (reset)
      $countones({s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, v0_ff.valid,
                  ph_valid_ff, r0_ff.valid, g_valid_ff}) <= 1)
      else $error("more than one sample in the datapath");
endmodule
